FILE: sv/ptd_pkg.sv
// Shared constants and types for the point-to-triangle squared distance unit.
`timescale 1ns / 1ps
`default_nettype none

package ptd_pkg;

    // Width of the distance result port
    localparam int unsigned OUT_WIDTH = 34;

    // Number of axes and of triangle edges
    localparam int unsigned NUM_AXES  = 3;
    localparam int unsigned NUM_EDGES = 3;

    // Region flags that travel with an item behind the arithmetic
    typedef struct packed {
        logic interior;
        logic degen;
    } t_region;

endpackage

`default_nettype wire

FILE: sv/ptd_div.sv
// Pipelined restoring divider, one quotient bit per register stage.
`timescale 1ns / 1ps
`default_nettype none

module ptd_div #(
    parameter int unsigned DW = 40,
    parameter int unsigned QW = 36
) (
    input  wire logic               i_clk,
    input  wire logic [DW+QW-1:0]   i_num,
    input  wire logic [DW-1:0]      i_den,
    output logic      [QW-1:0]      o_quo
);

    logic [DW-1:0] r_rem [QW];
    logic [QW-1:0] r_low [QW];
    logic [QW-1:0] r_quo [QW];
    logic [DW-1:0] r_den [QW];
    logic [DW-1:0] n_rem [QW];
    logic [QW-1:0] n_low [QW];
    logic [QW-1:0] n_quo [QW];

    for (genvar k = 0; k < QW; k++) begin : g_stage
        logic [DW-1:0] w_rem_in;
        logic [QW-1:0] w_low_in;
        logic [QW-1:0] w_quo_in;
        logic [DW-1:0] w_den_in;
        logic [DW:0]   w_trial;
        logic          w_ge;

        // Take the top of the numerator at the first stage, else the previous stage
        if (k == 0) begin : g_first
            assign w_rem_in = i_num[DW+QW-1:QW];
            assign w_low_in = i_num[QW-1:0];
            assign w_quo_in = '0;
            assign w_den_in = i_den;
        end else begin : g_next
            assign w_rem_in = r_rem[k-1];
            assign w_low_in = r_low[k-1];
            assign w_quo_in = r_quo[k-1];
            assign w_den_in = r_den[k-1];
        end

        // Shift in one numerator bit and subtract the divisor where it fits
        assign w_trial  = {w_rem_in, w_low_in[QW-1]};
        assign w_ge     = (w_trial >= {1'b0, w_den_in});
        assign n_rem[k] = w_ge ? DW'(w_trial - {1'b0, w_den_in}) : w_trial[DW-1:0];
        assign n_low[k] = w_low_in << 1;
        assign n_quo[k] = {w_quo_in[QW-2:0], w_ge};

        always_ff @(posedge i_clk) begin
            r_rem[k] <= n_rem[k];
            r_low[k] <= n_low[k];
            r_quo[k] <= n_quo[k];
            r_den[k] <= w_den_in;
        end
    end

    assign o_quo = r_quo[QW-1];

endmodule

`default_nettype wire

FILE: sv/point_triangle_distance_squared_unit.sv
// Top level of the point-to-triangle squared distance unit.
`timescale 1ns / 1ps
`default_nettype none

// Squared distance from a query point to a 3D triangle.
// Command channel: an item (point and three corners, signed Q7.8) is taken
// at each rising edge with start high and busy low. busy is always low, so
// a new item may enter every cycle.
// Result channel: o_valid is high for exactly one cycle with o_dist_squared
// (floored squared distance, 2^-16 units) and o_degenerate (flat triangle,
// whatever the region; the distance to corner 0 is given then).
// Six arithmetic stages feed four dividers that each produce one quotient
// bit per stage (2*COORD_WIDTH + 4 stages), then one output register.
// Throughput: one item per cycle, results in input order.
// Reset clears every valid bit; items in flight are dropped. The receiver
// cannot stall, so the pipeline advances on every clock.
module point_triangle_distance_squared_unit #(
    parameter int unsigned COORD_WIDTH = 16
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic signed [COORD_WIDTH-1:0] i_point_x,
    input  wire logic signed [COORD_WIDTH-1:0] i_point_y,
    input  wire logic signed [COORD_WIDTH-1:0] i_point_z,
    input  wire logic signed [COORD_WIDTH-1:0] i_corner0_x,
    input  wire logic signed [COORD_WIDTH-1:0] i_corner0_y,
    input  wire logic signed [COORD_WIDTH-1:0] i_corner0_z,
    input  wire logic signed [COORD_WIDTH-1:0] i_corner1_x,
    input  wire logic signed [COORD_WIDTH-1:0] i_corner1_y,
    input  wire logic signed [COORD_WIDTH-1:0] i_corner1_z,
    input  wire logic signed [COORD_WIDTH-1:0] i_corner2_x,
    input  wire logic signed [COORD_WIDTH-1:0] i_corner2_y,
    input  wire logic signed [COORD_WIDTH-1:0] i_corner2_z,
    output logic                               o_valid,
    output logic [ptd_pkg::OUT_WIDTH-1:0]      o_dist_squared,
    output logic                               o_degenerate
);

    localparam int unsigned W    = COORD_WIDTH;
    localparam int unsigned DFW  = W + 1;         // coordinate difference
    localparam int unsigned PW   = 2 * W + 3;     // cross product component
    localparam int unsigned TW   = 2 * W + 5;     // signed edge parameter
    localparam int unsigned EW   = 2 * W + 4;     // squared lengths
    localparam int unsigned QW   = 2 * W + 4;     // quotient width
    localparam int unsigned SW   = 4 * W + 8;     // second-order products
    localparam int unsigned NQW  = 3 * W + 4;     // signed n.q
    localparam int unsigned AW   = 3 * W + 3;     // |n.q|
    localparam int unsigned LO   = (AW + 1) / 2;
    localparam int unsigned HI   = AW - LO;
    localparam int unsigned NUMW = SW + QW;
    localparam int unsigned LAT  = QW + 7;
    localparam int unsigned NA   = ptd_pkg::NUM_AXES;
    localparam int unsigned NE   = ptd_pkg::NUM_EDGES;

    // ---------------- stage A: differences ----------------
    logic signed [W-1:0]   w_p  [NA];
    logic signed [W-1:0]   w_v  [NE][NA];
    logic signed [DFW-1:0] n_a_f [NE][NA];
    logic signed [DFW-1:0] n_a_d [NE][NA];
    logic signed [DFW-1:0] r_a_f [NE][NA];
    logic signed [DFW-1:0] r_a_d [NE][NA];
    logic                  r_a_vld;

    assign w_p[0] = i_point_x;
    assign w_p[1] = i_point_y;
    assign w_p[2] = i_point_z;
    assign w_v[0][0] = i_corner0_x;
    assign w_v[0][1] = i_corner0_y;
    assign w_v[0][2] = i_corner0_z;
    assign w_v[1][0] = i_corner1_x;
    assign w_v[1][1] = i_corner1_y;
    assign w_v[1][2] = i_corner1_z;
    assign w_v[2][0] = i_corner2_x;
    assign w_v[2][1] = i_corner2_y;
    assign w_v[2][2] = i_corner2_z;

    // Edge j runs from corner j to corner j+1; f is the point seen from corner j
    always_comb begin
        for (int j = 0; j < NE; j++) begin
            for (int i = 0; i < NA; i++) begin
                n_a_f[j][i] = DFW'(w_p[i]) - DFW'(w_v[j][i]);
                n_a_d[j][i] = DFW'(w_v[(j+1)%NE][i]) - DFW'(w_v[j][i]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_f <= n_a_f;
        r_a_d <= n_a_d;
    end

    // ---------------- stage B: first products ----------------
    logic signed [PW-1:0]  n_b_n  [NA];
    logic signed [PW-1:0]  n_b_c  [NE][NA];
    logic signed [TW-1:0]  n_b_t  [NE];
    logic signed [TW-1:0]  n_b_ee [NE];
    logic signed [TW-1:0]  n_b_ff [NE];
    logic signed [PW-1:0]  r_b_n  [NA];
    logic signed [PW-1:0]  r_b_c  [NE][NA];
    logic signed [TW-1:0]  r_b_t  [NE];
    logic [EW-1:0]         r_b_ee [NE];
    logic [EW-1:0]         r_b_ff [NE];
    logic signed [DFW-1:0] r_b_q  [NA];
    logic                  r_b_vld;

    // Normal from the closing edge and the first edge; edge crosses for side tests; edge dot products
    always_comb begin
        for (int i = 0; i < NA; i++) begin
            n_b_n[i] = PW'(r_a_d[2][(i+1)%NA]) * PW'(r_a_d[0][(i+2)%NA])
                     - PW'(r_a_d[2][(i+2)%NA]) * PW'(r_a_d[0][(i+1)%NA]);
        end
        for (int j = 0; j < NE; j++) begin
            n_b_t[j]  = '0;
            n_b_ee[j] = '0;
            n_b_ff[j] = '0;
            for (int i = 0; i < NA; i++) begin
                n_b_c[j][i] = PW'(r_a_d[j][(i+1)%NA]) * PW'(r_a_f[j][(i+2)%NA])
                            - PW'(r_a_d[j][(i+2)%NA]) * PW'(r_a_f[j][(i+1)%NA]);
                n_b_t[j]  = n_b_t[j]  + TW'(r_a_f[j][i]) * TW'(r_a_d[j][i]);
                n_b_ee[j] = n_b_ee[j] + TW'(r_a_d[j][i]) * TW'(r_a_d[j][i]);
                n_b_ff[j] = n_b_ff[j] + TW'(r_a_f[j][i]) * TW'(r_a_f[j][i]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_b_n <= n_b_n;
        r_b_c <= n_b_c;
        r_b_t <= n_b_t;
        for (int j = 0; j < NE; j++) begin
            r_b_ee[j] <= n_b_ee[j][EW-1:0];
            r_b_ff[j] <= n_b_ff[j][EW-1:0];
        end
        r_b_q <= r_a_f[0];
    end

    // ---------------- stage C: second products ----------------
    logic signed [SW-1:0]  n_c_nn;
    logic signed [NQW-1:0] n_c_nq;
    logic signed [SW-1:0]  n_c_s  [NE];
    logic signed [SW-1:0]  n_c_cc [NE];
    logic [SW-1:0]         r_c_nn;
    logic signed [NQW-1:0] r_c_nq;
    logic [NE-1:0]         r_c_in;
    logic [SW-1:0]         r_c_cc [NE];
    logic signed [TW-1:0]  r_c_t  [NE];
    logic [EW-1:0]         r_c_ee [NE];
    logic [EW-1:0]         r_c_ff [NE];
    logic                  r_c_degen;
    logic                  r_c_vld;

    always_comb begin
        n_c_nn = '0;
        n_c_nq = '0;
        for (int i = 0; i < NA; i++) begin
            n_c_nn = n_c_nn + SW'(r_b_n[i]) * SW'(r_b_n[i]);
            n_c_nq = n_c_nq + NQW'(r_b_n[i]) * NQW'(r_b_q[i]);
        end
        for (int j = 0; j < NE; j++) begin
            n_c_s[j]  = '0;
            n_c_cc[j] = '0;
            for (int i = 0; i < NA; i++) begin
                n_c_s[j]  = n_c_s[j]  + SW'(r_b_c[j][i]) * SW'(r_b_n[i]);
                n_c_cc[j] = n_c_cc[j] + SW'(r_b_c[j][i]) * SW'(r_b_c[j][i]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_c_nn <= n_c_nn;
        r_c_nq <= n_c_nq;
        for (int j = 0; j < NE; j++) begin
            r_c_in[j] <= !n_c_s[j][SW-1];
            r_c_cc[j] <= n_c_cc[j];
        end
        r_c_t     <= r_b_t;
        r_c_ee    <= r_b_ee;
        r_c_ff    <= r_b_ff;
        r_c_degen <= (r_b_n[0] == '0) && (r_b_n[1] == '0) && (r_b_n[2] == '0);
    end

    // ---------------- stage D: region choice, edge operands ----------------
    logic [SW-1:0]     n_d_enum [NE];
    logic [EW-1:0]     n_d_eden [NE];
    logic [AW-1:0]     r_d_nqa;
    logic [SW-1:0]     r_d_nn;
    logic [SW-1:0]     r_d_enum [NE];
    logic [EW-1:0]     r_d_eden [NE];
    logic [EW-1:0]     r_d_ff0;
    ptd_pkg::t_region  r_d_reg;
    logic              r_d_vld;

    // Clamp to the near corner, the far corner, or the perpendicular foot
    always_comb begin
        for (int j = 0; j < NE; j++) begin
            if (r_c_t[j] <= 0) begin
                n_d_enum[j] = SW'(r_c_ff[j]);
                n_d_eden[j] = EW'(1);
            end else if (r_c_t[j] >= $signed({1'b0, r_c_ee[j]})) begin
                n_d_enum[j] = SW'(r_c_ff[(j+1)%NE]);
                n_d_eden[j] = EW'(1);
            end else begin
                n_d_enum[j] = r_c_cc[j];
                n_d_eden[j] = r_c_ee[j];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_d_nqa          <= r_c_nq[NQW-1] ? AW'(-r_c_nq) : AW'(r_c_nq);
        r_d_nn           <= r_c_nn;
        r_d_enum         <= n_d_enum;
        r_d_eden         <= n_d_eden;
        r_d_ff0          <= r_c_ff[0];
        r_d_reg.degen    <= r_c_degen;
        r_d_reg.interior <= !r_c_degen && (&r_c_in);
    end

    // ---------------- stage E: partial products of (n.q)^2 ----------------
    logic [2*HI-1:0]   r_e_hh;
    logic [HI+LO-1:0]  r_e_hl;
    logic [2*LO-1:0]   r_e_ll;
    logic [SW-1:0]     r_e_nn;
    logic [SW-1:0]     r_e_enum [NE];
    logic [EW-1:0]     r_e_eden [NE];
    logic [EW-1:0]     r_e_ff0;
    ptd_pkg::t_region  r_e_reg;
    logic              r_e_vld;

    always_ff @(posedge i_clk) begin
        r_e_hh   <= (2*HI)'(r_d_nqa[AW-1:LO]) * (2*HI)'(r_d_nqa[AW-1:LO]);
        r_e_hl   <= (HI+LO)'(r_d_nqa[AW-1:LO]) * (HI+LO)'(r_d_nqa[LO-1:0]);
        r_e_ll   <= (2*LO)'(r_d_nqa[LO-1:0]) * (2*LO)'(r_d_nqa[LO-1:0]);
        r_e_nn   <= r_d_nn;
        r_e_enum <= r_d_enum;
        r_e_eden <= r_d_eden;
        r_e_ff0  <= r_d_ff0;
        r_e_reg  <= r_d_reg;
    end

    // ---------------- stage F: combine partial products ----------------
    logic [NUMW-1:0]   r_f_num;
    logic [SW-1:0]     r_f_nn;
    logic [SW-1:0]     r_f_enum [NE];
    logic [EW-1:0]     r_f_eden [NE];
    logic [EW-1:0]     r_f_ff0;
    ptd_pkg::t_region  r_f_reg;
    logic              r_f_vld;

    always_ff @(posedge i_clk) begin
        r_f_num  <= (NUMW'(r_e_hh) << (2 * LO)) + (NUMW'(r_e_hl) << (LO + 1))
                  + NUMW'(r_e_ll);
        r_f_nn   <= r_e_nn;
        r_f_enum <= r_e_enum;
        r_f_eden <= r_e_eden;
        r_f_ff0  <= r_e_ff0;
        r_f_reg  <= r_e_reg;
    end

    // ---------------- dividers ----------------
    logic [QW-1:0] w_qi;
    logic [QW-1:0] w_qe [NE];

    ptd_div #(
        .DW (SW),
        .QW (QW)
    ) u_div_plane (
        .i_clk (i_clk),
        .i_num (r_f_num),
        .i_den (r_f_nn),
        .o_quo (w_qi)
    );

    for (genvar j = 0; j < NE; j++) begin : g_edge
        ptd_div #(
            .DW (EW),
            .QW (QW)
        ) u_div_edge (
            .i_clk (i_clk),
            .i_num (r_f_enum[j]),
            .i_den (r_f_eden[j]),
            .o_quo (w_qe[j])
        );
    end

    // Carry region flags and corner distance alongside the dividers
    logic [EW-1:0]     r_g_ff0 [QW];
    ptd_pkg::t_region  r_g_reg [QW];
    logic [QW-1:0]     r_g_vld;

    always_ff @(posedge i_clk) begin
        r_g_ff0[0] <= r_f_ff0;
        r_g_reg[0] <= r_f_reg;
        for (int k = 1; k < QW; k++) begin
            r_g_ff0[k] <= r_g_ff0[k-1];
            r_g_reg[k] <= r_g_reg[k-1];
        end
    end

    // ---------------- output: nearest edge and final choice ----------------
    logic [QW-1:0]               w_q01;
    logic [QW-1:0]               w_qmin;
    logic [QW-1:0]               n_dist;
    logic [ptd_pkg::OUT_WIDTH-1:0] r_out_dist;
    logic                        r_out_degen;
    logic                        r_out_vld;

    always_comb begin
        w_q01  = (w_qe[1] < w_qe[0]) ? w_qe[1] : w_qe[0];
        w_qmin = (w_qe[2] < w_q01) ? w_qe[2] : w_q01;
        if (r_g_reg[QW-1].degen) begin
            n_dist = r_g_ff0[QW-1];
        end else if (r_g_reg[QW-1].interior) begin
            n_dist = w_qi;
        end else begin
            n_dist = w_qmin;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_dist  <= ptd_pkg::OUT_WIDTH'(n_dist);
        r_out_degen <= r_g_reg[QW-1].degen;
    end

    // Advance valid bits; reset drops everything in flight
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld   <= 1'b0;
            r_b_vld   <= 1'b0;
            r_c_vld   <= 1'b0;
            r_d_vld   <= 1'b0;
            r_e_vld   <= 1'b0;
            r_f_vld   <= 1'b0;
            r_g_vld   <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_a_vld   <= start && !busy;
            r_b_vld   <= r_a_vld;
            r_c_vld   <= r_b_vld;
            r_d_vld   <= r_c_vld;
            r_e_vld   <= r_d_vld;
            r_f_vld   <= r_e_vld;
            r_g_vld   <= {r_g_vld[QW-2:0], r_f_vld};
            r_out_vld <= r_g_vld[QW-1];
        end
    end

    assign busy           = 1'b0;
    assign o_valid        = r_out_vld;
    assign o_dist_squared = r_out_dist;
    assign o_degenerate   = r_out_degen;

`ifndef SYNTHESIS
    // A result leaves exactly the pipeline latency after its item came in
    a_latency : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, LAT))
        else $error("result without matching item");

    // A flat triangle has a zero normal length
    a_flat_norm : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_c_degen |-> (r_c_nn == '0))
        else $error("degenerate flag with nonzero normal");

    // Flat and interior flags are never set together
    a_region : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_d_vld |=> !(r_e_reg.degen && r_e_reg.interior))
        else $error("conflicting region flags");
`endif

endmodule

`default_nettype wire

FILE: bench/tb_point_triangle_distance_squared_unit.sv
// Self-checking bench for the point-to-triangle squared distance unit.
`timescale 1ns / 1ps

class dist_scoreboard;
    logic [33:0] dist_q[$];
    logic        degen_q[$];
    int          errors;
    int          checked;
    int          degen_seen;
    int          inside_seen;

    function new();
        errors = 0;
        checked = 0;
        degen_seen = 0;
        inside_seen = 0;
    endfunction

    // Report one mismatch and count it
    task report(input string what, input logic [33:0] got, input logic [33:0] want);
        $display("mismatch %0s: got %0d expected %0d", what, got, want);
        errors++;
    endtask

    // Note an accepted item with its expected result
    function void note_item(input logic [33:0] sq, input logic degen);
        dist_q.push_back(sq);
        degen_q.push_back(degen);
    endfunction

    // Compare a result with the oldest expectation
    task check_result(input logic [33:0] sq, input logic degen);
        logic [33:0] want_dist;
        logic        want_degen;
        if (dist_q.size() == 0) begin
            report("unexpected result", sq, '0);
        end else begin
            want_dist = dist_q.pop_front();
            want_degen = degen_q.pop_front();
            checked++;
            if (want_degen) degen_seen++;
            if (sq !== want_dist) report("dist_squared", sq, want_dist);
            if (degen !== want_degen)
                report("degenerate", {33'b0, degen}, {33'b0, want_degen});
        end
    endtask
endclass

module tb_point_triangle_distance_squared_unit;

    localparam int CW = 16;
    localparam int LATENCY = 2 * CW + 11;
    localparam int WATCHDOG = 2000;

    typedef logic signed [CW-1:0] t_coord;
    typedef logic signed [127:0]  t_wide;
    typedef logic signed [63:0]   t_vec[3];

    logic   i_clk = 0;
    logic   i_rst_n = 0;
    logic   start = 0;
    logic   busy;
    t_coord pt[3];
    t_coord c0[3];
    t_coord c1[3];
    t_coord c2[3];
    logic   o_valid;
    logic [ptd_pkg::OUT_WIDTH-1:0] o_dist_squared;
    logic   o_degenerate;

    dist_scoreboard sb;
    int  idle_cycles;
    int  sent;
    bit  calm;

    initial begin
        for (int a = 0; a < 3; a++) begin
            pt[a] = '0; c0[a] = '0; c1[a] = '0; c2[a] = '0;
        end
    end

    point_triangle_distance_squared_unit #(.COORD_WIDTH(CW)) i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_point_x(pt[0]), .i_point_y(pt[1]), .i_point_z(pt[2]),
        .i_corner0_x(c0[0]), .i_corner0_y(c0[1]), .i_corner0_z(c0[2]),
        .i_corner1_x(c1[0]), .i_corner1_y(c1[1]), .i_corner1_z(c1[2]),
        .i_corner2_x(c2[0]), .i_corner2_y(c2[1]), .i_corner2_z(c2[2]),
        .o_valid(o_valid), .o_dist_squared(o_dist_squared),
        .o_degenerate(o_degenerate)
    );

    always #5 i_clk = ~i_clk;

    function automatic void vec_sub(output t_vec r, input t_vec a, input t_vec b);
        for (int k = 0; k < 3; k++) r[k] = a[k] - b[k];
    endfunction

    function automatic void vec_cross(output t_vec r, input t_vec a, input t_vec b);
        r[0] = a[1] * b[2] - a[2] * b[1];
        r[1] = a[2] * b[0] - a[0] * b[2];
        r[2] = a[0] * b[1] - a[1] * b[0];
    endfunction

    function automatic t_wide wide_dot(input t_vec a, input t_vec b);
        t_wide s;
        s = '0;
        for (int k = 0; k < 3; k++) s += t_wide'(a[k]) * t_wide'(b[k]);
        return s;
    endfunction

    // Squared distance from p to segment a-b
    function automatic t_wide segment_dist(input t_vec p, input t_vec a, input t_vec b);
        t_vec  f, e, g, c;
        t_wide t, ee;
        vec_sub(f, p, a);
        vec_sub(e, b, a);
        t = wide_dot(f, e);
        ee = wide_dot(e, e);
        if (t <= 0) return wide_dot(f, f);
        if (t >= ee) begin
            vec_sub(g, p, b);
            return wide_dot(g, g);
        end
        vec_cross(c, f, e);
        return wide_dot(c, c) / ee;
    endfunction

    function automatic bit inner_side(input t_vec p, input t_vec a, input t_vec b,
                                      input t_vec n);
        t_vec e, f, c;
        vec_sub(e, b, a);
        vec_sub(f, p, a);
        vec_cross(c, e, f);
        return wide_dot(c, n) >= 0;
    endfunction

    // Predict distance and flat flag for one query
    task automatic predict_distance(output logic [33:0] sq, output logic degen,
                                    output bit in_tri);
        t_vec  p, v0, v1, v2, e0, e1, n, q;
        t_wide d, best, nq;
        for (int k = 0; k < 3; k++) begin
            p[k] = 64'(pt[k]); v0[k] = 64'(c0[k]); v1[k] = 64'(c1[k]); v2[k] = 64'(c2[k]);
        end
        vec_sub(e0, v1, v0);
        vec_sub(e1, v2, v0);
        vec_cross(n, e0, e1);
        vec_sub(q, p, v0);
        degen = 0;
        in_tri = 0;
        if (n[0] == 0 && n[1] == 0 && n[2] == 0) begin
            best = wide_dot(q, q);
            degen = 1;
        end else if (inner_side(p, v0, v1, n) && inner_side(p, v1, v2, n) &&
                     inner_side(p, v2, v0, n)) begin
            nq = wide_dot(n, q);
            best = (nq * nq) / wide_dot(n, n);
            in_tri = 1;
        end else begin
            best = segment_dist(p, v0, v1);
            d = segment_dist(p, v1, v2);
            if (d < best) best = d;
            d = segment_dist(p, v2, v0);
            if (d < best) best = d;
        end
        sq = best[33:0];
    endtask

    // Offer one item, sometimes after a random gap, and hold it until it is taken
    task automatic send_item();
        logic [33:0] sq;
        logic        degen;
        bit          in_tri;
        int          gap;
        if (!calm && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 5);
            start <= 0;
            repeat (gap) @(negedge i_clk);
        end
        predict_distance(sq, degen, in_tri);
        start <= 1;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        sb.note_item(sq, degen);
        if (in_tri) sb.inside_seen++;
        sent++;
        @(negedge i_clk);
    endtask

    function automatic t_coord pick_coord(input int mode);
        case (mode)
            0: return t_coord'($urandom);
            1: return t_coord'($urandom_range(0, 1) ? 16'sh7fff : 16'sh8000);
            default: return t_coord'($signed($urandom_range(0, 2048)) - 1024);
        endcase
    endfunction

    task automatic set_tri(input int ax, input int ay, input int bx, input int by,
                           input int cx, input int cy);
        c0[0] = t_coord'(ax); c0[1] = t_coord'(ay); c0[2] = '0;
        c1[0] = t_coord'(bx); c1[1] = t_coord'(by); c1[2] = '0;
        c2[0] = t_coord'(cx); c2[1] = t_coord'(cy); c2[2] = '0;
    endtask

    task automatic set_point(input int x, input int y, input int z);
        pt[0] = t_coord'(x); pt[1] = t_coord'(y); pt[2] = t_coord'(z);
    endtask

    // Sample results on the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) sb.check_result(o_dist_squared, o_degenerate);
    end

    // Watchdog on cycles without any item moving
    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid || !i_rst_n) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        int mode;
        int wait_cycles;
        sb = new();
        idle_cycles = 0;
        sent = 0;
        calm = 0;
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1;
        @(negedge i_clk);

        // Directed: regions around a right triangle in the plane z = 0
        set_tri(0, 0, 256, 0, 0, 256);
        set_point(64, 64, 100); send_item();      // interior, above plane
        set_point(64, 64, -100); send_item();     // interior, below plane
        set_point(128, 128, 0); send_item();      // on hypotenuse
        set_point(0, 0, 0); send_item();          // on a vertex
        set_point(-50, -50, 7); send_item();      // beyond vertex 0
        set_point(400, -20, 3); send_item();      // beyond vertex 1
        set_point(-20, 400, -3); send_item();     // beyond vertex 2
        set_point(128, -60, 9); send_item();      // past edge 0-1
        set_point(300, 300, 1); send_item();      // past edge 1-2
        set_point(-60, 128, 2); send_item();      // past edge 2-0
        // Zero-area: collinear corners, then all corners equal
        set_tri(0, 0, 100, 100, 200, 200);
        set_point(50, 60, 70); send_item();
        set_tri(5, 5, 5, 5, 5, 5);
        set_point(-5, 9, 1); send_item();
        // Extremes of the field range
        for (int a = 0; a < 3; a++) begin
            pt[a] = 16'sh7fff; c0[a] = 16'sh8000; c1[a] = 16'sh8000; c2[a] = 16'sh8000;
        end
        c1[0] = 16'sh7fff; c2[1] = 16'sh7fff;
        send_item();
        for (int a = 0; a < 3; a++) begin
            pt[a] = 16'sh8000; c0[a] = 16'sh7fff; c1[a] = 16'sh7fff; c2[a] = 16'sh7fff;
        end
        c1[2] = 16'sh8000; c2[0] = 16'sh8000;
        send_item();
        for (int a = 0; a < 3; a++) begin
            pt[a] = 16'sh8000; c0[a] = 16'sh8000; c1[a] = 16'sh8000; c2[a] = 16'sh8000;
        end
        send_item();

        // Random: half full-range, the rest boundary or small values, some flat
        for (int n = 0; n < 840; n++) begin
            if (n >= 700) calm = 1;
            mode = $urandom_range(0, 9);
            for (int a = 0; a < 3; a++) begin
                pt[a] = pick_coord(mode < 5 ? 0 : (mode == 5 ? 1 : 2));
                c0[a] = pick_coord(mode < 5 ? 0 : (mode == 5 ? 1 : 2));
                c1[a] = pick_coord(mode < 5 ? 0 : (mode == 5 ? 1 : 2));
                c2[a] = pick_coord(mode < 5 ? 0 : (mode == 5 ? 1 : 2));
            end
            // Drop the point near the triangle plane to reach the interior case
            if (mode == 7) begin
                for (int a = 0; a < 3; a++)
                    pt[a] = t_coord'((int'(c0[a]) + int'(c1[a]) + int'(c2[a])) / 3
                                     + $signed($urandom_range(0, 8)) - 4);
            end
            // Collinear corners for the flat-triangle case
            if (mode == 8) begin
                for (int a = 0; a < 3; a++) begin
                    c1[a] = t_coord'(int'(c0[a]) + ($signed($urandom_range(0, 40)) - 20));
                    c2[a] = t_coord'(2 * int'(c1[a]) - int'(c0[a]));
                end
            end
            send_item();
        end
        start <= 0;

        // Drain, then wait out the pipeline before the report
        wait_cycles = 0;
        while (sb.dist_q.size() != 0 && wait_cycles < 20 * LATENCY) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        repeat (LATENCY + 5) @(posedge i_clk);

        $display("covered %0d items, %0d results checked, %0d in the interior case",
                 sent, sb.checked, sb.inside_seen);
        $display("flat triangles met: %0d, results left over: %0d",
                 sb.degen_seen, sb.dist_q.size());
        if (sb.errors == 0 && sb.dist_q.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule

FILE: point_triangle_distance_squared_unit.f
sv/ptd_pkg.sv
sv/ptd_div.sv
sv/point_triangle_distance_squared_unit.sv
bench/tb_point_triangle_distance_squared_unit.sv
